### rtl/web_pkg.sv
// Shared types and constants for the EAPOL BSSID filter.
package web_pkg;

  localparam int unsigned TableEntriesDefault = 32;
  localparam logic [63:0] EapolSnap = 64'hAAAA03000000888E;
  localparam logic [7:0] TypeData = 8'h08;
  localparam logic [7:0] TypeQos = 8'h88;
  localparam logic [7:0] TypeBeacon = 8'h80;
  localparam logic [1:0] DsToAp = 2'b01;
  localparam logic [1:0] DsNone = 2'b00;
  localparam logic [11:0] PosMax = 12'd4095;
  localparam logic [11:0] NeedQos = 12'd34;
  localparam logic [11:0] NeedData = 12'd32;
  localparam logic [11:0] NeedBeacon = 12'd22;
  localparam logic RegMode = 1'b0;
  localparam logic RegHeaderLen = 1'b1;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One lookup request walking down the cell chain.
  typedef struct packed {
    logic        active;
    logic        collect;
    logic        eapol;
    logic        beacon;
    logic [47:0] bssid;
    logic        found;
    logic        free_seen;
    logic        wrote;
    logic        keep_beacon;
  } probe_t;

  typedef struct packed {
    logic        keep_eapol;
    logic        keep_beacon;
    logic        is_eapol;
    logic        new_network;
    logic        table_full;
    logic [47:0] bssid;
  } result_t;

endpackage

### rtl/web_if.sv
// Valid/ready channel interfaces for the filter.
interface web_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface web_out_if;
  logic        valid;
  logic        ready;
  logic        keep_eapol;
  logic        keep_beacon;
  logic        is_eapol;
  logic        new_network;
  logic        table_full;
  logic [47:0] bssid;
  modport source (output valid, keep_eapol, keep_beacon, is_eapol, new_network, table_full,
                  bssid, input ready);
  modport sink (input valid, keep_eapol, keep_beacon, is_eapol, new_network, table_full,
                bssid, output ready);
endinterface

interface web_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/wlan_eapol_bssid_filter_top.sv
// Top level of the 802.11 EAPOL BSSID filter.
// The block takes one frame byte per cycle, but for the stalls below. On the last byte of
// a data, QoS data or beacon frame that is long enough, it sends a request down a row of
// TABLE_ENTRIES table cells, one cell per cycle: a lookup pass, and in collect mode for
// an EAPOL BSSID not yet known a second pass that stores it in the lowest free cell,
// if there is one. The result is offered once the last pass has left the row; any other
// frame end offers its all-zero result in the next cycle. Input waits during the table
// walk and while a result is pending, and resumes in the cycle after the result is
// taken; every other byte is accepted without waiting. No clearing pass is needed
// after reset.
module wlan_eapol_bssid_filter_top #(
  parameter int unsigned TABLE_ENTRIES = web_pkg::TableEntriesDefault
) (
  input logic clk,
  input logic rst,
  web_in_if.sink   in_ch,
  web_out_if.source out_ch,
  web_cfg_if.sink  cfg
);
  import web_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 2);

  state_t      state, state_next;
  logic        mode;
  logic [7:0]  header_len;
  logic [11:0] pos;
  logic [7:0]  ftype, fflags;
  logic [7:0]  ftype_next, fflags_next;
  logic [47:0] addr4, addr10, addr16;
  logic [47:0] addr4_next, addr10_next, addr16_next;
  logic [63:0] llc_plain, llc_qos;
  logic [63:0] llc_plain_next, llc_qos_next;
  logic [CntW-1:0] cnt;
  logic        second;
  probe_t      req, head, tail, rescan_req;
  result_t     res;
  logic        out_valid;
  logic        accept;
  logic [11:0] rel, len;
  logic        is_data, is_qos, is_beacon, short, eapol;
  logic        candidate, rescan;
  logic [47:0] pick;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      header_len <= 8'd0;
    end else if (cfg.valid) begin
      if (cfg.index == {7'd0, RegMode}) mode <= cfg.data[0];
      else if (cfg.index == {7'd0, RegHeaderLen}) header_len <= cfg.data;
    end
  end

  assign in_ch.ready = state == ST_RECV && !out_valid;
  assign accept = in_ch.valid && in_ch.ready;
  assign rel = pos - {4'd0, header_len};

  // Captured fields with the offered byte included, so the last byte of a frame counts.
  always_comb begin
    ftype_next = ftype;
    fflags_next = fflags;
    addr4_next = addr4;
    addr10_next = addr10;
    addr16_next = addr16;
    llc_plain_next = llc_plain;
    llc_qos_next = llc_qos;
    if (pos >= {4'd0, header_len}) begin
      if (rel == 12'd0) ftype_next = in_ch.frame_byte;
      if (rel == 12'd1) fflags_next = in_ch.frame_byte;
      if (rel >= 12'd4 && rel <= 12'd9) addr4_next = {addr4[39:0], in_ch.frame_byte};
      if (rel >= 12'd10 && rel <= 12'd15) addr10_next = {addr10[39:0], in_ch.frame_byte};
      if (rel >= 12'd16 && rel <= 12'd21) addr16_next = {addr16[39:0], in_ch.frame_byte};
      if (rel >= 12'd24 && rel <= 12'd31)
        llc_plain_next = {llc_plain[55:0], in_ch.frame_byte};
      if (rel >= 12'd26 && rel <= 12'd33) llc_qos_next = {llc_qos[55:0], in_ch.frame_byte};
    end
  end

  // Length after this byte, and classification of the finished frame.
  always_comb begin
    logic [11:0] p1;
    p1 = (pos < PosMax) ? pos + 12'd1 : pos;
    len = (p1 >= {4'd0, header_len}) ? p1 - {4'd0, header_len} : 12'd0;
    is_data = ftype_next == TypeData;
    is_qos = ftype_next == TypeQos;
    is_beacon = ftype_next == TypeBeacon;
    short = len < (is_qos ? NeedQos : (is_data ? NeedData : NeedBeacon));
    if (fflags_next[1:0] == DsToAp) pick = addr4_next;
    else if (fflags_next[1:0] == DsNone) pick = addr16_next;
    else pick = addr10_next;
    eapol = (is_data && llc_plain_next == EapolSnap) || (is_qos && llc_qos_next == EapolSnap);
    candidate = (is_data || is_qos || is_beacon) && !short;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; ftype <= '0; fflags <= '0;
      addr4 <= '0; addr10 <= '0; addr16 <= '0; llc_plain <= '0; llc_qos <= '0;
    end else if (accept) begin
      if (in_ch.frame_end) begin
        pos <= '0; ftype <= '0; fflags <= '0;
        addr4 <= '0; addr10 <= '0; addr16 <= '0; llc_plain <= '0; llc_qos <= '0;
      end else begin
        if (pos < PosMax) pos <= pos + 12'd1;
        ftype <= ftype_next;
        fflags <= fflags_next;
        addr4 <= addr4_next;
        addr10 <= addr10_next;
        addr16 <= addr16_next;
        llc_plain <= llc_plain_next;
        llc_qos <= llc_qos_next;
      end
    end
  end

  // A collect-mode EAPOL request that found nothing goes round again to be stored.
  assign rescan = !second && tail.collect && tail.eapol && !tail.found;

  always_comb begin
    rescan_req = tail;
    rescan_req.active = 1'b1;
    rescan_req.free_seen = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
      out_valid <= 1'b0;
      cnt <= '0;
      second <= 1'b0;
      req.active <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_RECV: begin
          if (accept && in_ch.frame_end) begin
            if (candidate) begin
              res <= '{keep_eapol: 1'b0, keep_beacon: 1'b0, is_eapol: eapol,
                       new_network: 1'b0, table_full: 1'b0, bssid: pick};
              req <= '{active: 1'b1, collect: !mode, eapol: eapol, beacon: is_beacon,
                       bssid: pick, found: 1'b0, free_seen: 1'b1, wrote: 1'b0,
                       keep_beacon: 1'b0};
              cnt <= '0;
              second <= 1'b0;
            end else begin
              res <= '0;
              req.active <= 1'b0;
              out_valid <= 1'b1;
            end
          end else begin
            req.active <= 1'b0;
            if (out_valid && out_ch.ready) out_valid <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (cnt == CntW'(TABLE_ENTRIES)) begin
            cnt <= '0;
            if (rescan) begin
              second <= 1'b1;
              req <= rescan_req;
            end else begin
              req.active <= 1'b0;
              res.keep_eapol <= !tail.collect && tail.eapol && tail.found;
              res.keep_beacon <= tail.keep_beacon;
              res.new_network <= second && tail.wrote;
              res.table_full <= second && !tail.wrote;
              out_valid <= 1'b1;
            end
          end else begin
            cnt <= cnt + 1'b1;
            req.active <= 1'b0;
          end
        end
        default: req.active <= 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    head = req;
    case (state)
      ST_RECV: if (accept && in_ch.frame_end && candidate) state_next = ST_SCAN;
      ST_SCAN: if (cnt == CntW'(TABLE_ENTRIES) && !rescan) state_next = ST_RECV;
      default: state_next = ST_RECV;
    endcase
  end

  web_chain #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_chain (
    .clk(clk), .rst(rst), .head(head), .tail(tail)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.keep_eapol = res.keep_eapol;
  assign out_ch.keep_beacon = res.keep_beacon;
  assign out_ch.is_eapol = res.is_eapol;
  assign out_ch.new_network = res.new_network;
  assign out_ch.table_full = res.table_full;
  assign out_ch.bssid = res.bssid;

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !in_ch.ready) else $error("input taken during table walk");
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res.new_network && res.table_full)) else $error("new and full both set");
  a_mode_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res.keep_eapol || res.keep_beacon) |-> !res.new_network && !res.table_full)
    else $error("fields of both modes set");
endmodule

### rtl/web_cell.sv
// One table entry: compares, records and passes the request to the next cell.
module web_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  web_pkg::probe_t probe_in,
  output web_pkg::probe_t probe_out
);
  import web_pkg::*;

  logic [47:0] entry;
  logic        valid;
  logic        saved;
  logic        hit;
  logic        take;
  probe_t      probe_next;

  assign hit  = probe_in.active && valid && entry == probe_in.bssid;
  // The first free cell is claimed only if no valid entry anywhere holds the BSSID,
  // so the decision to write waits for the whole chain: a first pass finds,
  // and the write happens as the request passes the first free cell.
  assign take = probe_in.active && probe_in.collect && probe_in.eapol && !probe_in.found
                && !probe_in.free_seen && !valid;

  always_comb begin
    probe_next = probe_in;
    if (hit) begin
      probe_next.found = 1'b1;
      if (!probe_in.collect && probe_in.beacon && !saved) probe_next.keep_beacon = 1'b1;
    end
    if (probe_in.active && !valid) probe_next.free_seen = 1'b1;
    if (take) probe_next.wrote = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
      saved <= 1'b0;
    end else begin
      if (take) begin
        valid <= 1'b1;
        saved <= 1'b0;
      end
      if (hit && !probe_in.collect && probe_in.beacon) saved <= 1'b1;
    end
    if (take) entry <= probe_in.bssid;
  end

  always_ff @(posedge clk) begin
    if (rst) probe_out.active <= 1'b0;
    else probe_out <= probe_next;
  end
endmodule

### rtl/web_chain.sv
// Row of table cells that a request walks through: a lookup pass, then, when needed, a write pass.
module web_chain #(
  parameter int unsigned TABLE_ENTRIES = web_pkg::TableEntriesDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  web_pkg::probe_t head,
  output web_pkg::probe_t tail
);
  import web_pkg::*;

  probe_t link [TABLE_ENTRIES+1];

  assign link[0] = head;
  assign tail = link[TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    web_cell u_cell (
      .clk(clk), .rst(rst), .clear(1'b0),
      .probe_in(link[g]), .probe_out(link[g+1])
    );
  end
endmodule
